// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication check, held off while reset is asserted.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/b64e_pkg.sv -----
// Types, constants and the character table of the base64 stream encoder.
package b64e_pkg;

  // Default depth of the group queue between front and back.
  localparam int B64E_QUEUE_DEPTH = 2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='
  localparam logic [6:0] PLUS_CHAR = 7'h2B; // '+'
  localparam logic [6:0] SLASH_CHAR = 7'h2F; // '/'

  // One closed group of up to three bytes.
  typedef struct packed {
    logic [23:0] bits;    // first byte in 23:16, missing bytes zero
    logic [1:0]  nbytes;  // real bytes in the group, 1..3
    logic        last;    // group ends the message
  } grp_t;

  // Standard alphabet lookup for one sextet.
  function automatic logic [6:0] b64_char(input logic [5:0] idx);
    logic [6:0] ch;
    if (idx < 6'd26) begin
      ch = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      ch = 7'h61 + {1'b0, idx - 6'd26};
    end else if (idx < 6'd62) begin
      ch = 7'h30 + {1'b0, idx - 6'd52};
    end else if (idx == 6'd62) begin
      ch = PLUS_CHAR;
    end else begin
      ch = SLASH_CHAR;
    end
    return ch;
  endfunction

endpackage

// ----- rtl/core/base64_stream_encoder.sv -----
// Top level of the base64 stream encoder: front, group queue and back.
//
// Input channel: one raw byte per item (in_data_byte) with in_last_byte
// marking the final byte of a message. Output channel: one ASCII character
// per item (out_char), out_last_char set on the final character.
// Bytes are gathered in groups of three; a group closes on its third byte
// or on a last byte, and yields four characters of the standard alphabet,
// '=' standing in for positions past the real bytes.
// The group that a closing byte completes is written into the queue register,
// and its first character is then loaded into the output register; the rest
// follow one per cycle while the receiver is ready. The back end thus emits
// four characters per group, and bytes that do not close a group are taken
// every cycle.
// A closed group waits in a QUEUE_DEPTH-entry queue; when the queue is
// full only a byte that would close a group is held off.
// If the receiver stalls, the current character holds in the output
// register and the queue fills, then input stalls on group closure.
// Synchronous reset clears pending bytes, queue and output valid.
module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] out_char,
  output logic       out_last_char
);
  import b64e_pkg::*;

  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  grp_t push_grp;
  grp_t head;

  b64e_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push         (push),
    .push_grp     (push_grp),
    .q_full       (q_full)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  b64e_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

// ----- rtl/core/b64e_front.sv -----
// Front end: collects bytes into groups and hands closed groups to the queue.
module b64e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_last_byte,
  output logic              push,
  output b64e_pkg::grp_t    push_grp,
  input  logic              q_full
);
  import b64e_pkg::*;

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [1:0]  held;
  logic        closes;
  logic        accept;

  // A stray count of three behaves as two
  assign held   = (cnt_r == 2'd3) ? 2'd2 : cnt_r;
  assign closes = (held == 2'd2) || in_last_byte;

  // Only an item that closes a group needs room in the queue
  assign in_ready = !q_full || !closes;
  assign accept   = in_valid && in_ready;
  assign push     = accept && closes;

  // Group assembly, missing bytes as zero
  always_comb begin
    push_grp.nbytes = held + 2'd1;
    push_grp.last   = in_last_byte;
    case (held)
      2'd0:    push_grp.bits = {in_data_byte, 16'h0000};
      2'd1:    push_grp.bits = {pend_r[15:8], in_data_byte, 8'h00};
      default: push_grp.bits = {pend_r, in_data_byte};
    endcase
  end

  // Pending byte store
  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (closes) begin
        pend_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end else if (held == 2'd0) begin
        pend_nxt = {in_data_byte, 8'h00};
        cnt_nxt  = 2'd1;
      end else begin
        pend_nxt = {pend_r[15:8], in_data_byte};
        cnt_nxt  = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/b64e_queue.sv -----
// Small ring queue of closed groups between front and back.
`include "assert_macros.svh"
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::B64E_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::grp_t push_grp,
  input  logic           pop,
  output b64e_pkg::grp_t head,
  output logic           full,
  output logic           empty
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  grp_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_grp;
  end

  `ASSERT_IMPL(a_no_push_full, push, !full || pop, "group pushed into a full queue")
  `ASSERT_IMPL(a_no_pop_empty, pop, !empty, "group popped from an empty queue")
  `ASSERT_CLK(a_count_bound, count_r <= CNT_W'(DEPTH), "queue fill count out of range")

endmodule

// ----- rtl/core/b64e_back.sv -----
// Back end: turns each queued group into four characters, one per item.
`include "assert_macros.svh"
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  b64e_pkg::grp_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [6:0]     out_char,
  output logic           out_last_char
);
  import b64e_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  logic [6:0] char_r;
  logic       last_r;
  logic       load;
  logic       emit;
  logic [5:0] sextet;
  logic [6:0] ch;

  // Output register is free when empty or being taken
  assign load = !out_valid_r || out_ready;
  assign emit = load && !q_empty;
  assign pop  = emit && (idx_r == 2'd3);

  // Sextet select and character lookup
  always_comb begin
    case (idx_r)
      2'd0:    sextet = head.bits[23:18];
      2'd1:    sextet = head.bits[17:12];
      2'd2:    sextet = head.bits[11:6];
      default: sextet = head.bits[5:0];
    endcase
    ch = (idx_r <= head.nbytes) ? b64_char(sextet) : PAD_CHAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      if (load) out_valid_r <= !q_empty;
      if (emit) idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= ch;
      last_r <= head.last && (idx_r == 2'd3);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;

  `ASSERT_IMPL(a_mid_group_head, idx_r != 2'd0, !q_empty, "group left queue mid-emission")
  `ASSERT_IMPL(a_last_wraps, out_valid_r && last_r, idx_r == 2'd0,
    "last char shown before group completed")

endmodule

// ----- tb/sv/b64_char_checker.sv -----
// Checker for the base64 stream encoder: predicts characters from accepted bytes and compares.
module b64_char_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [6:0] out_char,
  input  logic       out_last_char,
  output int         chars_due,
  output int         fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [6:0] ch;
    logic       last;
  } enc_char_t;

  string alphabet_str =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  enc_char_t   due_chars[$];
  logic [15:0] held_bytes;
  logic [1:0]  held_count;

  initial begin
    chars_due = 0;
    fail_count = 0;
    held_bytes = '0;
    held_count = '0;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [6:0] sextet_char(input logic [5:0] sx);
    byte c;
    c = alphabet_str[sx];
    return c[6:0];
  endfunction

  // Fold one byte into the pending group; a closing byte yields four characters.
  task automatic encode_byte(input logic [7:0] b, input logic fin);
    logic [1:0]  held;
    int          n;
    logic [23:0] grp;
    enc_char_t   c;
    held = (held_count == 2'd3) ? 2'd2 : held_count;
    n = held + 1;
    if (n < 3 && !fin) begin
      if (held == 2'd0) held_bytes = {b, 8'h00};
      else held_bytes[7:0] = b;
      held_count = n[1:0];
    end else begin
      case (held)
        2'd0: grp = {b, 16'h0000};
        2'd1: grp = {held_bytes[15:8], b, 8'h00};
        default: grp = {held_bytes, b};
      endcase
      for (int k = 0; k < 4; k++) begin
        // positions past the real bytes are padding
        c.ch = (k <= n) ? sextet_char(grp[23 - 6*k -: 6]) : b64e_pkg::PAD_CHAR;
        c.last = (k == 3) && fin;
        due_chars.push_back(c);
      end
      held_bytes = '0;
      held_count = '0;
    end
  endtask

  // Output side is checked before the input side so a same-edge byte cannot be matched early.
  always @(posedge clk) begin : watch
    enc_char_t want;
    if (!rst_n) begin
      due_chars.delete();
      held_bytes = '0;
      held_count = '0;
      chars_due <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_chars.size() == 0) begin
          report($sformatf("unexpected char 0x%02h last=%0b", out_char, out_last_char));
        end else begin
          want = due_chars.pop_front();
          if (out_char !== want.ch)
            report($sformatf("out_char 0x%02h, want 0x%02h", out_char, want.ch));
          if (out_last_char !== want.last)
            report($sformatf("out_last_char %0b, want %0b", out_last_char, want.last));
        end
      end
      if (in_valid && in_ready) encode_byte(in_data_byte, in_last_byte);
      chars_due <= due_chars.size();
    end
  end

endmodule

// ----- tb/sv/base64_stream_encoder_tb.sv -----
// Testbench top for the base64 stream encoder: clock, reset, byte stimulus and verdict.
module base64_stream_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 250;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_char;
  logic       out_last_char;
  int         chars_due;
  int         fail_count;

  bit no_idle = 1'b0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int ready_left = 0;

  always #6 clk = ~clk;

  base64_stream_encoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last_char(out_last_char)
  );

  b64_char_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char     (out_char),
    .out_last_char(out_last_char),
    .chars_due    (chars_due),
    .fail_count   (fail_count)
  );

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // Offer one item and hold it until accepted.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (!(in_valid && in_ready));
    bytes_sent++;
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) push_byte(pick_byte(), i == len - 1);
  endtask

  // Receiver: runs of ready and stalls, always ready in burst phases.
  always @(posedge clk) begin
    int len;
    if (no_idle) begin
      out_ready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if ($urandom_range(0, 99) < 65) begin
      out_ready <= 1'b1;
      ready_left = $urandom_range(0, 11);
    end else begin
      len = pick_gap();
      out_ready <= 1'b0;
      ready_left = (len == 0) ? 0 : len - 1;
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("base64_stream_encoder test failed");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one, two and three byte groups at the extremes.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b1);
    // full group not last ("++++"), then a two byte tail
    push_byte(8'hFB, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hBE, 1'b0);
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b1);
    // full group that ends the message
    push_byte(8'h4D, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'h6E, 1'b1);
    // two full groups then a one byte tail
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'hA5, 1'b1);

    // Random messages, mostly short, some in back-to-back bursts.
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 7);
      else if (r < 95) len = $urandom_range(8, 20);
      else len = $urandom_range(30, 45);
      send_message(len);
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;

    // Drain, then let any stray characters show up.
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("base64_stream_encoder test passed");
    end else begin
      $display("base64_stream_encoder test failed");
    end
    $finish;
  end

endmodule
